>>> design/ibmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibmd_pkg
// Shared types and constants of the inode block map decomposer: result
// codes, register indexes, reset values and the job and config records.
// ----------------------------------------------------------------------------
package ibmd_pkg;

    // result kind codes
    localparam logic [1:0] KIND_SLOT  = 2'd0;
    localparam logic [1:0] KIND_INDEX = 2'd1;
    localparam logic [1:0] KIND_RANGE = 2'd2;

    // register indexes, byte address bits [3:2]
    localparam logic [1:0] REG_DIRECT_COUNT = 2'd0;
    localparam logic [1:0] REG_ENTRIES      = 2'd1;
    localparam logic [1:0] REG_LEVEL_COUNT  = 2'd2;

    // register reset values and the spans that follow from them
    localparam logic [4:0]  DIRECT_COUNT_RESET = 5'd7;
    localparam logic [14:0] ENTRIES_RESET      = 15'd1024;
    localparam logic [1:0]  LEVEL_COUNT_RESET  = 2'd2;
    localparam logic [29:0] SPAN2_RESET        = 30'd1048576;
    localparam logic [44:0] SPAN3_RESET        = 45'd1073741824;

    // widths
    localparam int unsigned QUO_W  = 15;
    localparam int unsigned SPAN_W = 45;

    // classification handed from front to back
    typedef enum logic [1:0] {
        JOB_DIRECT,
        JOB_TREE,
        JOB_RANGE
    } job_kind_t;

    typedef struct packed {
        job_kind_t   jk;
        logic [1:0]  lv;
        logic [31:0] off;
    } job_t;

    // live configuration and precomputed tree spans
    typedef struct packed {
        logic [4:0]  direct_count;
        logic [14:0] entries;
        logic [1:0]  lim;
        logic [14:0] span1;
        logic [29:0] span2;
        logic [44:0] span3;
    } cfg_t;

endpackage
`default_nettype wire

>>> design/inode_block_map_decomposer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inode_block_map_decomposer_unit
// Locates a file block in an inode's block map: direct slot, or indirect
// tree slot followed by one index per level, most significant first, or out of range.
// ----------------------------------------------------------------------------
//  channel   signals                          transaction
//  request   req_valid / req_ready            block_num
//  result    res_valid / res_ready            kind, value, depth, last
//  config    psel penable pwrite paddr ...    32-bit register write / read
//
//  front: classifies a block as direct, in one of the trees, or out of
//  range; back: emits the slot, then the level one index taken straight
//  from the offset, and each higher level index by a 15-step restoring
//  divide. Reset clears all control state; after an entries write the
//  spans follow through span2_reg and then span3_reg. A two-entry queue
//  lets the front take the next block while the back works or the result
//  stalls.
// ----------------------------------------------------------------------------
module inode_block_map_decomposer_unit #(
    parameter int MAX_LEVELS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [31:0] block_num,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [1:0]       kind,
    output logic [31:0]      value,
    output logic [1:0]       depth,
    output logic             last
);
    import ibmd_pkg::*;

    cfg_t cfg;
    job_t push_job;
    job_t pop_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign pready = 1'b1;

    // configuration registers
    ibmd_cfg #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // classification
    ibmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .block_num  (block_num),
        .cfg        (cfg),
        .push       (push),
        .job        (push_job),
        .full       (full)
    );

    // job queue
    ibmd_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_job),
        .full  (full),
        .pop   (pop),
        .rdata (pop_job),
        .empty (empty)
    );

    // result generation
    ibmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (pop_job),
        .empty     (empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .value     (value),
        .depth     (depth),
        .last      (last)
    );

endmodule
`default_nettype wire

>>> design/ibmd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibmd_cfg
// Configuration registers behind the APB-style port, plus the registered
// tree spans entries^2 and entries^3 derived from them.
// ----------------------------------------------------------------------------
module ibmd_cfg #(
    parameter int MAX_LEVELS = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output ibmd_pkg::cfg_t     cfg
);
    import ibmd_pkg::*;

    logic [4:0]  direct_count_reg, direct_count_next;
    logic [14:0] entries_reg, entries_next;
    logic [1:0]  level_count_reg, level_count_next;
    logic [29:0] span2_reg, span2_next;
    logic [44:0] span3_reg, span3_next;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    // register writes, unknown indexes ignored
    always_comb
    begin
        direct_count_next = direct_count_reg;
        entries_next      = entries_reg;
        level_count_next  = level_count_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                REG_DIRECT_COUNT: direct_count_next = pwdata[4:0];
                REG_ENTRIES:      entries_next      = pwdata[14:0];
                REG_LEVEL_COUNT:  level_count_next  = pwdata[1:0];
                default:          ;
            endcase
        end
    end

    // span chain, one multiply per stage
    always_comb
    begin
        span2_next = 30'(entries_reg) * 30'(entries_reg);
        span3_next = 45'(span2_reg) * 45'(entries_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_count_reg <= DIRECT_COUNT_RESET;
            entries_reg      <= ENTRIES_RESET;
            level_count_reg  <= LEVEL_COUNT_RESET;
            span2_reg        <= SPAN2_RESET;
            span3_reg        <= SPAN3_RESET;
        end
        else
        begin
            direct_count_reg <= direct_count_next;
            entries_reg      <= entries_next;
            level_count_reg  <= level_count_next;
            span2_reg        <= span2_next;
            span3_reg        <= span3_next;
        end
    end

    // read back
    always_comb
    begin
        case (paddr[3:2])
            REG_DIRECT_COUNT: prdata = {27'd0, direct_count_reg};
            REG_ENTRIES:      prdata = {17'd0, entries_reg};
            REG_LEVEL_COUNT:  prdata = {30'd0, level_count_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // live view, tree count limited by the build
    always_comb
    begin
        cfg.direct_count = direct_count_reg;
        cfg.entries      = entries_reg;
        cfg.lim          = (int'(level_count_reg) < MAX_LEVELS) ? level_count_reg
                                                                : 2'(MAX_LEVELS);
        cfg.span1        = entries_reg;
        cfg.span2        = span2_reg;
        cfg.span3        = span3_reg;
    end

endmodule
`default_nettype wire

>>> design/ibmd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibmd_front
// Accepts a file block and classifies it: direct slot, one of the indirect
// trees with its offset inside that tree, or out of range.
// ----------------------------------------------------------------------------
module ibmd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire logic [31:0]   block_num,
    input  wire ibmd_pkg::cfg_t cfg,
    output logic               push,
    output ibmd_pkg::job_t     job,
    input  wire logic          full
);
    import ibmd_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_WALK,
        F_PUSH
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [31:0] off_reg, off_next;
    logic [2:0]  lv_reg, lv_next;
    job_t        job_reg, job_next;
    logic [SPAN_W-1:0] span;

    assign req_ready = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH) && !full;
    assign job       = job_reg;

    // span of the tree under test
    always_comb
    begin
        case (lv_reg)
            3'd1:    span = SPAN_W'(cfg.span1);
            3'd2:    span = SPAN_W'(cfg.span2);
            3'd3:    span = cfg.span3;
            default: span = '0;
        endcase
    end

    // classification walk, one tree a cycle
    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        lv_next    = lv_reg;
        job_next   = job_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (req_valid)
                begin
                    off_next   = block_num;
                    state_next = F_CLASS;
                end
            end
            F_CLASS:
            begin
                if (off_reg < 32'(cfg.direct_count))
                begin
                    job_next   = '{jk: JOB_DIRECT, lv: 2'd0, off: off_reg};
                    state_next = F_PUSH;
                end
                else
                begin
                    off_next   = off_reg - 32'(cfg.direct_count);
                    lv_next    = 3'd1;
                    state_next = F_WALK;
                end
            end
            F_WALK:
            begin
                if (lv_reg > {1'b0, cfg.lim})
                begin
                    job_next   = '{jk: JOB_RANGE, lv: 2'd0, off: 32'd0};
                    state_next = F_PUSH;
                end
                else if (SPAN_W'(off_reg) < span)
                begin
                    job_next   = '{jk: JOB_TREE, lv: lv_reg[1:0], off: off_reg};
                    state_next = F_PUSH;
                end
                else
                begin
                    off_next = off_reg - span[31:0];
                    lv_next  = lv_reg + 3'd1;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            off_reg   <= '0;
            lv_reg    <= '0;
            job_reg   <= '{jk: JOB_DIRECT, lv: 2'd0, off: 32'd0};
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            lv_reg    <= lv_next;
            job_reg   <= job_next;
        end
    end

endmodule
`default_nettype wire

>>> design/ibmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibmd_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ibmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ibmd_pkg::job_t wdata,
    output logic                full,
    input  wire logic           pop,
    output ibmd_pkg::job_t      rdata,
    output logic                empty
);
    import ibmd_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

>>> design/ibmd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibmd_back
// Turns a job into its slot or range result, then one index per tree level,
// above level one by a one-bit-a-cycle restoring divide by the entry span.
// ----------------------------------------------------------------------------
module ibmd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ibmd_pkg::cfg_t cfg,
    input  wire ibmd_pkg::job_t job,
    input  wire logic           empty,
    output logic                pop,
    output logic                res_valid,
    input  wire logic           res_ready,
    output logic [1:0]          kind,
    output logic [31:0]         value,
    output logic [1:0]          depth,
    output logic                last
);
    import ibmd_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_DIV,
        B_EMIT
    } bstate_t;

    bstate_t           state_reg, state_next;
    logic [31:0]       off_reg, off_next;
    logic [1:0]        level_reg, level_next;
    logic [SPAN_W-1:0] dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              res_valid_reg, res_valid_next;
    logic [1:0]        kind_reg, kind_next;
    logic [31:0]       value_reg, value_next;
    logic [1:0]        depth_reg, depth_next;
    logic              last_reg, last_next;
    logic              out_free;
    logic [29:0]       divisor;
    logic              q_bit;

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign depth     = depth_reg;
    assign last      = last_reg;

    // span of one entry at the current level (two or three)
    assign divisor = (level_reg == 2'd2) ? 30'(cfg.entries) : cfg.span2;
    assign q_bit   = (SPAN_W'(off_reg) >= dsh_reg);

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        level_next     = level_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        depth_next     = depth_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        case (state_reg)
            // first transaction of a job: slot or out of range
            B_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop            = 1'b1;
                    res_valid_next = 1'b1;
                    case (job.jk)
                        JOB_DIRECT:
                        begin
                            kind_next  = KIND_SLOT;
                            value_next = job.off;
                            depth_next = 2'd0;
                            last_next  = 1'b1;
                        end
                        JOB_TREE:
                        begin
                            kind_next  = KIND_SLOT;
                            value_next = 32'(cfg.direct_count) + 32'(job.lv) - 32'd1;
                            depth_next = job.lv;
                            last_next  = 1'b0;
                            off_next   = job.off;
                            level_next = job.lv;
                            state_next = B_SETUP;
                        end
                        default:
                        begin
                            kind_next  = KIND_RANGE;
                            value_next = 32'd0;
                            depth_next = 2'd0;
                            last_next  = 1'b1;
                        end
                    endcase
                end
            end
            // load divisor, level one needs no divide
            B_SETUP:
            begin
                if (level_reg == 2'd1)
                begin
                    quo_next   = off_reg[QUO_W-1:0];
                    state_next = B_EMIT;
                end
                else
                begin
                    dsh_next   = {1'b0, divisor, 14'd0};
                    quo_next   = '0;
                    cnt_next   = 4'(QUO_W - 1);
                    state_next = B_DIV;
                end
            end
            // restoring divide step
            B_DIV:
            begin
                if (q_bit)
                begin
                    off_next = off_reg - dsh_reg[31:0];
                end
                quo_next = {quo_reg[QUO_W-2:0], q_bit};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = B_EMIT;
                end
            end
            // index transaction, remainder carries down
            B_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    kind_next      = KIND_INDEX;
                    value_next     = 32'(quo_reg);
                    depth_next     = level_reg;
                    last_next      = (level_reg == 2'd1);
                    if (level_reg == 2'd1)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        level_next = level_reg - 2'd1;
                        state_next = B_SETUP;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            off_reg       <= '0;
            level_reg     <= '0;
            dsh_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= KIND_SLOT;
            value_reg     <= '0;
            depth_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_reg       <= off_next;
            level_reg     <= level_next;
            dsh_reg       <= dsh_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            kind_reg      <= kind_next;
            value_reg     <= value_next;
            depth_reg     <= depth_next;
            last_reg      <= last_next;
        end
    end

endmodule
`default_nettype wire
